@@ hw/rtl/dge_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dge_pkg
// Shared types, sizes and helpers of the dataflow graph evaluator.
// ----------------------------------------------------------------------------
package dge_pkg;

  localparam int MAX_NODES       = 64;
  localparam int MAX_VALUE_SLOTS = 256;
  localparam int MAX_INPUT_SLOTS = 512;

  localparam int NID_W  = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int VA_W   = $clog2(MAX_VALUE_SLOTS);
  localparam int VCNT_W = $clog2(MAX_VALUE_SLOTS + 1);
  localparam int IA_W   = $clog2(MAX_INPUT_SLOTS);
  localparam int ICNT_W = $clog2(MAX_INPUT_SLOTS + 1);
  localparam int CLR_DEPTH = (MAX_INPUT_SLOTS > MAX_VALUE_SLOTS) ?
                             MAX_INPUT_SLOTS : MAX_VALUE_SLOTS;
  localparam int CLR_W  = $clog2(CLR_DEPTH);

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    CMD_DEFINE  = 3'd0,
    CMD_CONNECT = 3'd1,
    CMD_SET     = 3'd2,
    CMD_EVAL    = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    FN_CONST   = 3'd0,
    FN_SUM     = 3'd1,
    FN_PROD    = 3'd2,
    FN_SOFTMAX = 3'd3,
    FN_IDENT   = 3'd4,
    FN_RELU    = 3'd5,
    FN_SCALAR  = 3'd6
  } fn_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_FUNCTION = 3'd1,
    ST_TABLE_FULL   = 3'd2,
    ST_SLOTS        = 3'd3,
    ST_RANGE        = 3'd4,
    ST_UNKNOWN      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_SRC, S_CHECK, S_RD_VAL,
    S_N_RD, S_N_LAT, S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [8:0]  target_index;
    logic [5:0]  target_node;
    logic [7:0]  source_index;
    logic [5:0]  source_node;
    logic [8:0]  dimension;
    logic [2:0]  function_code;
    logic [2:0]  command;
  } item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [5:0]  node_id;
    status_t     status;
  } result_t;

  typedef struct packed {
    fn_t               fn;
    logic [8:0]        dim;
    logic [ICNT_W-1:0] ib;
    logic [VCNT_W-1:0] ob;
  } node_ent_t;

  typedef struct packed {
    logic            valid;
    logic [VA_W-1:0] idx;
  } wire_ent_t;

  typedef struct packed {
    logic            we;
    logic [NID_W-1:0] waddr;
    node_ent_t       wdata;
    logic [NID_W-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic            we;
    logic [IA_W-1:0] waddr;
    wire_ent_t       wdata;
    logic [IA_W-1:0] raddr;
  } wire_req_t;

  typedef struct packed {
    logic            we;
    logic [VA_W-1:0] waddr;
    logic [31:0]     wdata;
    logic [VA_W-1:0] raddr;
  } val_req_t;

  function automatic logic [31:0] inputs_of(input fn_t fn, input logic [8:0] dim);
    logic [31:0] r;
    unique case (fn)
      FN_CONST:                     r = 32'd0;
      FN_SUM, FN_PROD, FN_SCALAR:   r = {22'd0, dim, 1'b0};
      default:                      r = 32'(dim);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] outputs_of(input fn_t fn, input logic [8:0] dim);
    return (fn == FN_SCALAR) ? 32'd1 : 32'(dim);
  endfunction

endpackage

@@ hw/rtl/dge_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dge_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/dge_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dge_alu
// Element unit: saturating sum, Q16.16 product, identity, positive part.
// ----------------------------------------------------------------------------
module dge_alu (
  input  logic              clk,
  input  logic              mul_en,
  input  dge_pkg::fn_t      fn,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic [31:0]       result
);

  logic signed [63:0] prod;
  logic signed [32:0] sum;
  logic signed [47:0] shifted;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= a * b;
    end
  end

  always_comb begin
    sum     = 33'(a) + 33'(b);
    shifted = prod[63:16];
    unique case (fn)
      dge_pkg::FN_SUM: begin
        if (sum > 33'sh0_7FFF_FFFF) result = 32'h7FFF_FFFF;
        else if (sum < -33'sh0_8000_0000) result = 32'h8000_0000;
        else result = sum[31:0];
      end
      dge_pkg::FN_PROD: begin
        if (shifted > 48'sh7FFF_FFFF) result = 32'h7FFF_FFFF;
        else if (shifted < -48'sh8000_0000) result = 32'h8000_0000;
        else result = shifted[31:0];
      end
      dge_pkg::FN_RELU: result = a[31] ? 32'd0 : a;
      default:          result = a;
    endcase
  end

endmodule

@@ hw/rtl/dge_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dge_ctrl
// Command sequencer: node table, wiring and value store access, evaluation.
// ----------------------------------------------------------------------------
module dge_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dge_pkg::item_t      in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output dge_pkg::result_t    res,
  output dge_pkg::node_req_t  node_req,
  input  dge_pkg::node_ent_t  node_rdata,
  output dge_pkg::wire_req_t  wire_req,
  input  dge_pkg::wire_ent_t  wire_rdata,
  output dge_pkg::val_req_t   val_req,
  input  logic [31:0]         val_rdata
);

  dge_pkg::state_t state, state_next;
  dge_pkg::item_t  itm;
  dge_pkg::node_ent_t src, ent;
  logic [dge_pkg::NCNT_W-1:0] node_count;
  logic [dge_pkg::ICNT_W-1:0] in_used;
  logic [dge_pkg::VCNT_W-1:0] val_used;
  logic [dge_pkg::NCNT_W-1:0] k;
  logic [8:0]  i;
  logic [dge_pkg::CLR_W-1:0] clr_cnt;
  logic        a_ok, b_ok, a_hit, b_hit;
  logic [31:0] opa, opb;
  logic [31:0] alu_res;

  dge_pkg::cmd_t cmd;
  logic [31:0] ni, no, src_no, tgt_ni, vs, slot_c, a_slot, b_slot, oaddr;
  logic        unknown, range_err, def_ok, elem_end, skip_node, is_unary;
  dge_pkg::status_t def_status;
  dge_pkg::status_t dec_status;

  dge_alu u_alu (
    .clk    (clk),
    .mul_en (state == dge_pkg::S_E4),
    .fn     (ent.fn),
    .a      (opa),
    .b      (opb),
    .result (alu_res)
  );

  always_comb begin
    cmd    = dge_pkg::cmd_t'(itm.command);
    ni     = dge_pkg::inputs_of(dge_pkg::fn_t'(itm.function_code), itm.dimension);
    no     = dge_pkg::outputs_of(dge_pkg::fn_t'(itm.function_code), itm.dimension);
    if (itm.function_code > 3'(dge_pkg::FN_SCALAR)) def_status = dge_pkg::ST_BAD_FUNCTION;
    else if (32'(node_count) >= dge_pkg::MAX_NODES) def_status = dge_pkg::ST_TABLE_FULL;
    else if (32'(in_used) + ni > dge_pkg::MAX_INPUT_SLOTS ||
             32'(val_used) + no > dge_pkg::MAX_VALUE_SLOTS) def_status = dge_pkg::ST_SLOTS;
    else def_status = dge_pkg::ST_OK;
    def_ok  = (def_status == dge_pkg::ST_OK);
    unknown = (32'(itm.source_node) >= 32'(node_count)) ||
              (cmd == dge_pkg::CMD_CONNECT && 32'(itm.target_node) >= 32'(node_count));
    unique case (cmd)
      dge_pkg::CMD_DEFINE: dec_status = def_status;
      dge_pkg::CMD_CONNECT, dge_pkg::CMD_SET, dge_pkg::CMD_READ:
        dec_status = unknown ? dge_pkg::ST_UNKNOWN : dge_pkg::ST_OK;
      default: dec_status = dge_pkg::ST_OK;
    endcase
    src_no  = dge_pkg::outputs_of(src.fn, src.dim);
    tgt_ni  = dge_pkg::inputs_of(node_rdata.fn, node_rdata.dim);
    vs      = 32'(src.ob) + 32'(itm.source_index);
    slot_c  = 32'(node_rdata.ib) + 32'(itm.target_index);
    range_err = (32'(itm.source_index) >= src_no) || (vs >= dge_pkg::MAX_VALUE_SLOTS) ||
                (cmd == dge_pkg::CMD_CONNECT &&
                 (32'(itm.target_index) >= tgt_ni || slot_c >= dge_pkg::MAX_INPUT_SLOTS));
    is_unary  = (ent.fn == dge_pkg::FN_IDENT) || (ent.fn == dge_pkg::FN_RELU);
    a_slot    = is_unary ? 32'(ent.ib) + 32'(i) : 32'(ent.ib) + {22'd0, i, 1'b0};
    b_slot    = a_slot + 32'd1;
    oaddr     = 32'(ent.ob) + 32'(i);
    elem_end  = (32'(i) >= 32'(ent.dim)) || (oaddr >= dge_pkg::MAX_VALUE_SLOTS);
    skip_node = (node_rdata.fn == dge_pkg::FN_CONST) ||
                (node_rdata.fn == dge_pkg::FN_SOFTMAX) ||
                (node_rdata.fn == dge_pkg::FN_SCALAR);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dge_pkg::S_CLEAR: if (32'(clr_cnt) == dge_pkg::CLR_DEPTH - 1) state_next = dge_pkg::S_IDLE;
      dge_pkg::S_IDLE:  if (in_valid) state_next = dge_pkg::S_DECODE;
      dge_pkg::S_DECODE: begin
        unique case (cmd)
          dge_pkg::CMD_CONNECT, dge_pkg::CMD_SET, dge_pkg::CMD_READ:
            state_next = unknown ? dge_pkg::S_DONE : dge_pkg::S_RD_SRC;
          dge_pkg::CMD_EVAL: state_next = dge_pkg::S_N_RD;
          default:           state_next = dge_pkg::S_DONE;
        endcase
      end
      dge_pkg::S_RD_SRC: state_next = dge_pkg::S_CHECK;
      dge_pkg::S_CHECK:
        state_next = (!range_err && cmd == dge_pkg::CMD_READ) ? dge_pkg::S_RD_VAL
                                                               : dge_pkg::S_DONE;
      dge_pkg::S_RD_VAL: state_next = dge_pkg::S_DONE;
      dge_pkg::S_N_RD:
        state_next = (k >= node_count) ? dge_pkg::S_DONE : dge_pkg::S_N_LAT;
      dge_pkg::S_N_LAT: state_next = skip_node ? dge_pkg::S_N_RD : dge_pkg::S_E0;
      dge_pkg::S_E0: state_next = elem_end ? dge_pkg::S_N_RD : dge_pkg::S_E1;
      dge_pkg::S_E1: state_next = dge_pkg::S_E2;
      dge_pkg::S_E2: state_next = dge_pkg::S_E3;
      dge_pkg::S_E3: state_next = dge_pkg::S_E4;
      dge_pkg::S_E4: state_next = dge_pkg::S_E5;
      dge_pkg::S_E5: state_next = dge_pkg::S_E0;
      dge_pkg::S_DONE: if (res_ready) state_next = dge_pkg::S_IDLE;
      default: state_next = dge_pkg::S_IDLE;
    endcase
  end

  // memory requests and handshake
  always_comb begin
    in_ready  = (state == dge_pkg::S_IDLE);
    res_valid = (state == dge_pkg::S_DONE);

    node_req.we       = (state == dge_pkg::S_DECODE) && (cmd == dge_pkg::CMD_DEFINE) && def_ok;
    node_req.waddr    = node_count[dge_pkg::NID_W-1:0];
    node_req.wdata.fn = dge_pkg::fn_t'(itm.function_code);
    node_req.wdata.dim = itm.dimension;
    node_req.wdata.ib = in_used;
    node_req.wdata.ob = val_used;
    unique case (state)
      dge_pkg::S_DECODE: node_req.raddr = dge_pkg::NID_W'(itm.source_node);
      dge_pkg::S_RD_SRC: node_req.raddr = dge_pkg::NID_W'(itm.target_node);
      default:           node_req.raddr = k[dge_pkg::NID_W-1:0];
    endcase

    wire_req.we    = 1'b0;
    wire_req.waddr = slot_c[dge_pkg::IA_W-1:0];
    wire_req.wdata.valid = 1'b1;
    wire_req.wdata.idx   = vs[dge_pkg::VA_W-1:0];
    wire_req.raddr = (state == dge_pkg::S_E1) ? b_slot[dge_pkg::IA_W-1:0]
                                              : a_slot[dge_pkg::IA_W-1:0];

    val_req.we    = 1'b0;
    val_req.waddr = vs[dge_pkg::VA_W-1:0];
    val_req.wdata = itm.value;
    val_req.raddr = (state == dge_pkg::S_CHECK) ? vs[dge_pkg::VA_W-1:0] : wire_rdata.idx;

    unique case (state)
      dge_pkg::S_CLEAR: begin
        wire_req.we    = (32'(clr_cnt) < dge_pkg::MAX_INPUT_SLOTS);
        wire_req.waddr = clr_cnt[dge_pkg::IA_W-1:0];
        wire_req.wdata = '0;
        val_req.we     = (32'(clr_cnt) < dge_pkg::MAX_VALUE_SLOTS);
        val_req.waddr  = clr_cnt[dge_pkg::VA_W-1:0];
        val_req.wdata  = '0;
      end
      dge_pkg::S_CHECK: begin
        wire_req.we = !range_err && (cmd == dge_pkg::CMD_CONNECT);
        val_req.we  = !range_err && (cmd == dge_pkg::CMD_SET);
      end
      dge_pkg::S_E5: begin
        val_req.we    = 1'b1;
        val_req.waddr = oaddr[dge_pkg::VA_W-1:0];
        val_req.wdata = alu_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dge_pkg::S_CLEAR;
      clr_cnt    <= '0;
      node_count <= '0;
      in_used    <= '0;
      val_used   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        dge_pkg::S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        dge_pkg::S_IDLE: if (in_valid) itm <= in_item;
        dge_pkg::S_DECODE: begin
          k              <= '0;
          res.status     <= dec_status;
          res.node_id    <= (cmd == dge_pkg::CMD_DEFINE && def_ok) ? 6'(node_count) : 6'd0;
          res.read_value <= '0;
          if (cmd == dge_pkg::CMD_DEFINE && def_ok) begin
            node_count <= node_count + 1'b1;
            in_used    <= in_used + dge_pkg::ICNT_W'(ni);
            val_used   <= val_used + dge_pkg::VCNT_W'(no);
          end
        end
        dge_pkg::S_RD_SRC: src <= node_rdata;
        dge_pkg::S_CHECK: if (range_err) res.status <= dge_pkg::ST_RANGE;
        dge_pkg::S_RD_VAL: res.read_value <= val_rdata;
        dge_pkg::S_N_LAT: begin
          ent <= node_rdata;
          i   <= '0;
          if (skip_node) k <= k + 1'b1;
        end
        dge_pkg::S_E0: begin
          a_ok <= a_slot < dge_pkg::MAX_INPUT_SLOTS;
          b_ok <= b_slot < dge_pkg::MAX_INPUT_SLOTS;
          if (elem_end) k <= k + 1'b1;
        end
        dge_pkg::S_E1: a_hit <= a_ok && wire_rdata.valid;
        dge_pkg::S_E2: begin
          opa   <= a_hit ? val_rdata : 32'd0;
          b_hit <= b_ok && wire_rdata.valid;
        end
        dge_pkg::S_E3: opb <= b_hit ? val_rdata : 32'd0;
        dge_pkg::S_E5: i <= i + 1'b1;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_def_room: assert property (@(posedge clk) disable iff (rst)
    node_req.we |-> 32'(node_count) < dge_pkg::MAX_NODES)
    else $error("node defined into a full table");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(in_used) <= dge_pkg::MAX_INPUT_SLOTS && 32'(val_used) <= dge_pkg::MAX_VALUE_SLOTS)
    else $error("slot usage beyond capacity");
  a_wire_valid: assert property (@(posedge clk) disable iff (rst)
    wire_req.we && state != dge_pkg::S_CLEAR |-> wire_req.wdata.valid)
    else $error("connect wrote an unconnected entry");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != dge_pkg::ST_OK |-> res.node_id == 6'd0 && res.read_value == 32'd0)
    else $error("error result carries payload");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |=> state == dge_pkg::S_IDLE || state == dge_pkg::S_DECODE)
    else $error("item accepted outside idle");
`endif

endmodule

@@ hw/rtl/dataflow_graph_evaluator.sv @@
`timescale 1ns / 1ps
// Evaluate walks the node table in order; for each computed element it reads
// its operands one after the other through the shared wiring and value store
// read ports (one access chain per element), then writes the result back.
// One command in flight; the next may enter in the cycle after the result leaves.
// Reset: synchronous; a clearing pass over max(input, value slots) = 512 addresses
// zeroes the wiring table and value store, s_axis_tready stays low meanwhile.
// ----------------------------------------------------------------------------
// dataflow_graph_evaluator
// Command-driven dataflow graph engine with memory-held state.
// ----------------------------------------------------------------------------
module dataflow_graph_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command, function_code, dimension, source_node, source_index,
  // target_node, target_index, value
  input  logic [dge_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, node_id, read_value
  output logic [dge_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  dge_pkg::node_req_t node_req;
  dge_pkg::wire_req_t wire_req;
  dge_pkg::val_req_t  val_req;
  dge_pkg::node_ent_t node_rdata;
  dge_pkg::wire_ent_t wire_rdata;
  logic [31:0]        val_rdata;
  dge_pkg::result_t   res, out_res;
  logic               res_valid, res_ready;

  assign res_ready    = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {7'd0, out_res};

  dge_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (dge_pkg::item_t'(s_axis_tdata[75:0])),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .node_req   (node_req),
    .node_rdata (node_rdata),
    .wire_req   (wire_req),
    .wire_rdata (wire_rdata),
    .val_req    (val_req),
    .val_rdata  (val_rdata)
  );

  dge_ram #(.WIDTH($bits(dge_pkg::node_ent_t)), .DEPTH(dge_pkg::MAX_NODES)) u_node_ram (
    .clk (clk), .we (node_req.we), .waddr (node_req.waddr), .wdata (node_req.wdata),
    .raddr (node_req.raddr), .rdata (node_rdata)
  );

  dge_ram #(.WIDTH($bits(dge_pkg::wire_ent_t)), .DEPTH(dge_pkg::MAX_INPUT_SLOTS)) u_wire_ram (
    .clk (clk), .we (wire_req.we), .waddr (wire_req.waddr), .wdata (wire_req.wdata),
    .raddr (wire_req.raddr), .rdata (wire_rdata)
  );

  dge_ram #(.WIDTH(32), .DEPTH(dge_pkg::MAX_VALUE_SLOTS)) u_val_ram (
    .clk (clk), .we (val_req.we), .waddr (val_req.waddr), .wdata (val_req.wdata),
    .raddr (val_req.raddr), .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule
